// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the energy unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define SCE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checked at every rising edge, reset included.
`define SCE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/sce_pkg.sv -----
// ----------------------------------------------------------------------------
// sce_pkg
// Widths, register indexes and reset values of the diagonal energy unit.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int MAX_SITES_DEF = 32;
    localparam int STATE_W       = 32;
    localparam int COEF_W        = 32;
    localparam int SITE_W        = 6;
    localparam int ENERGY_W      = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int PIPE_DEPTH    = 7;

    localparam logic [SITE_W-1:0] SITE_COUNT_RST = 6'd32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COUPLING_V = 2'd0,
        REG_FIELD_H    = 2'd1,
        REG_SITE_COUNT = 2'd2
    } cfg_reg_t;

endpackage

// ----- hdl/sce_prefix.sv -----
// ----------------------------------------------------------------------------
// sce_prefix
// Two stages: per-group bit counts, then the running spin sums Q_t and the
// staggered sum A of the spin word.
// ----------------------------------------------------------------------------
module sce_prefix #(
    parameter int MAX_SITES = sce_pkg::MAX_SITES_DEF,
    localparam int NW = $clog2(MAX_SITES + 1),
    localparam int QW = $clog2(MAX_SITES) + 1,
    localparam int AW = $clog2(MAX_SITES + 1) + 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sce_pkg::STATE_W-1:0] in_state,
    input  logic [NW-1:0]               n_eff,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [QW-1:0]        q_out [1:MAX_SITES-1],
    output logic signed [AW-1:0]        a_out
);

    localparam int G  = (MAX_SITES + 7) / 8;
    localparam int CW = $clog2(MAX_SITES + 1);

    logic [MAX_SITES+31:0] bits_ext;

    logic [3:0]        loc_next  [1:MAX_SITES-1];
    logic [3:0]        loc_reg   [1:MAX_SITES-1];
    logic [3:0]        gtot_next [0:G-1];
    logic [3:0]        gtot_reg  [0:G-1];
    logic signed [3:0] altg_next [0:G-1];
    logic signed [3:0] altg_reg  [0:G-1];
    logic              v1_reg;
    logic              en1;

    logic [CW-1:0]        off_w [0:G-1];
    logic [CW-1:0]        cnt_w [1:MAX_SITES-1];
    logic signed [AW-1:0] a_sum;
    logic signed [QW-1:0] q_next [1:MAX_SITES-1];
    logic signed [QW-1:0] q_reg  [1:MAX_SITES-1];
    logic signed [AW-1:0] a_next;
    logic signed [AW-1:0] a_reg;
    logic                 v2_reg;
    logic                 en2;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Sites at 32 and above have no input bit and read as spin down.
    assign bits_ext = {{MAX_SITES{1'b0}}, in_state};

    always_comb begin
        for (int t = 1; t < MAX_SITES; t++) begin
            loc_next[t] = '0;
            for (int k = ((t - 1) / 8) * 8; k < t; k++) begin
                loc_next[t] = loc_next[t] + 4'(bits_ext[k]);
            end
        end
        for (int g = 0; g < G; g++) begin
            gtot_next[g] = '0;
            altg_next[g] = '0;
            for (int o = 0; o < 8; o++) begin
                if (8 * g + o < MAX_SITES) begin
                    gtot_next[g] = gtot_next[g] + 4'(bits_ext[8 * g + o]);
                    if (NW'(8 * g + o) < n_eff && bits_ext[8 * g + o]) begin
                        if (o % 2 == 1) begin
                            altg_next[g] = altg_next[g] + 4'sd1;
                        end else begin
                            altg_next[g] = altg_next[g] - 4'sd1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        off_w[0] = '0;
        for (int g = 1; g < G; g++) begin
            off_w[g] = off_w[g-1] + CW'(gtot_reg[g-1]);
        end
        for (int t = 1; t < MAX_SITES; t++) begin
            cnt_w[t]  = off_w[(t - 1) / 8] + CW'(loc_reg[t]);
            q_next[t] = QW'({cnt_w[t], 1'b0}) - QW'(t);
        end
        a_sum = '0;
        for (int g = 0; g < G; g++) begin
            a_sum = a_sum + AW'(altg_reg[g]);
        end
        a_next = a_sum <<< 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            loc_reg  <= loc_next;
            gtot_reg <= gtot_next;
            altg_reg <= altg_next;
        end
        if (en2) begin
            q_reg <= q_next;
            a_reg <= a_next;
        end
    end

    assign out_valid = v2_reg;
    assign q_out     = q_reg;
    assign a_out     = a_reg;

endmodule

// ----- hdl/sce_terms.sv -----
// ----------------------------------------------------------------------------
// sce_terms
// Three stages: squares and odd-site picks of the running sums, group sums,
// then the total K = sum(Q_t^2) - L(L-1)/2 - 2*sum(Q_t for odd t).
// ----------------------------------------------------------------------------
module sce_terms #(
    parameter int MAX_SITES = sce_pkg::MAX_SITES_DEF,
    localparam int NW  = $clog2(MAX_SITES + 1),
    localparam int QW  = $clog2(MAX_SITES) + 1,
    localparam int AW  = $clog2(MAX_SITES + 1) + 1,
    localparam int SQW = 2 * $clog2(MAX_SITES),
    localparam int KW  = SQW + 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [QW-1:0] q_in [1:MAX_SITES-1],
    input  logic signed [AW-1:0] a_in,
    input  logic [NW-1:0]        n_eff,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [KW-1:0] k_out,
    output logic signed [AW-1:0] a_out
);

    localparam int G    = (MAX_SITES + 7) / 8;
    localparam int QXW  = 2 * QW;
    localparam int SUMW = SQW + 6;
    localparam int BSW  = QW + 6;

    logic [SQW-1:0]       sq_next [1:MAX_SITES-1];
    logic [SQW-1:0]       sq_reg  [1:MAX_SITES-1];
    logic signed [QW-1:0] bq_next [1:MAX_SITES-1];
    logic signed [QW-1:0] bq_reg  [1:MAX_SITES-1];
    logic signed [AW-1:0] a3_reg;
    logic                 v3_reg;
    logic                 en3;

    logic [SQW+2:0]         sqg_next [0:G-1];
    logic [SQW+2:0]         sqg_reg  [0:G-1];
    logic signed [QW+2:0]   bqg_next [0:G-1];
    logic signed [QW+2:0]   bqg_reg  [0:G-1];
    logic signed [AW-1:0]   a4_reg;
    logic                   v4_reg;
    logic                   en4;

    logic [SUMW-1:0]        sq_sum;
    logic signed [BSW-1:0]  bq_sum;
    logic [2*NW-1:0]        pair_prod;
    logic signed [KW-1:0]   k_next;
    logic signed [KW-1:0]   k_reg;
    logic signed [AW-1:0]   a5_reg;
    logic                   v5_reg;
    logic                   en5;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    always_comb begin
        for (int t = 1; t < MAX_SITES; t++) begin
            if (NW'(t) < n_eff) begin
                sq_next[t] = SQW'(QXW'(q_in[t]) * QXW'(q_in[t]));
            end else begin
                sq_next[t] = '0;
            end
            if (NW'(t) < n_eff && t % 2 == 1) begin
                bq_next[t] = q_in[t];
            end else begin
                bq_next[t] = '0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < G; g++) begin
            sqg_next[g] = '0;
            bqg_next[g] = '0;
            for (int o = 0; o < 8; o++) begin
                if (8 * g + o + 1 < MAX_SITES) begin
                    sqg_next[g] = sqg_next[g] + (SQW + 3)'(sq_reg[8 * g + o + 1]);
                    bqg_next[g] = bqg_next[g] + (QW + 3)'(bq_reg[8 * g + o + 1]);
                end
            end
        end
    end

    always_comb begin
        sq_sum = '0;
        bq_sum = '0;
        for (int g = 0; g < G; g++) begin
            sq_sum = sq_sum + SUMW'(sqg_reg[g]);
            bq_sum = bq_sum + BSW'(bqg_reg[g]);
        end
        pair_prod = (2 * NW)'(n_eff) * (2 * NW)'(n_eff - 1'b1);
        k_next = KW'(sq_sum) - (KW'(bq_sum) <<< 1) - KW'(pair_prod >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en3) begin
                v3_reg <= in_valid;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            sq_reg <= sq_next;
            bq_reg <= bq_next;
            a3_reg <= a_in;
        end
        if (en4) begin
            sqg_reg <= sqg_next;
            bqg_reg <= bqg_next;
            a4_reg  <= a3_reg;
        end
        if (en5) begin
            k_reg  <= k_next;
            a5_reg <= a4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign k_out     = k_reg;
    assign a_out     = a5_reg;

endmodule

// ----- hdl/sce_combine.sv -----
// ----------------------------------------------------------------------------
// sce_combine
// Two stages: the coupling and field products, then the 64-bit energy sum
// E = 2*h*A + V*K held in the output register.
// ----------------------------------------------------------------------------
module sce_combine #(
    parameter int MAX_SITES = sce_pkg::MAX_SITES_DEF,
    localparam int AW = $clog2(MAX_SITES + 1) + 1,
    localparam int KW = 2 * $clog2(MAX_SITES) + 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [KW-1:0]                k_in,
    input  logic signed [AW-1:0]                a_in,
    input  logic signed [sce_pkg::COEF_W-1:0]   coupling_v,
    input  logic signed [sce_pkg::COEF_W-1:0]   field_h,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sce_pkg::ENERGY_W-1:0] energy
);

    localparam int PVW = sce_pkg::COEF_W + KW;
    localparam int PHW = sce_pkg::COEF_W + AW;

    logic signed [PVW-1:0] pv_next;
    logic signed [PVW-1:0] pv_reg;
    logic signed [PHW-1:0] ph_next;
    logic signed [PHW-1:0] ph_reg;
    logic                  v6_reg;
    logic                  en6;

    logic signed [sce_pkg::ENERGY_W-1:0] e_next;
    logic signed [sce_pkg::ENERGY_W-1:0] e_reg;
    logic                                v7_reg;
    logic                                en7;

    assign en7      = !v7_reg || out_ready;
    assign en6      = !v6_reg || en7;
    assign in_ready = en6;

    assign pv_next = PVW'(coupling_v) * PVW'(k_in);
    assign ph_next = PHW'(field_h) * PHW'(a_in);

    // Both products stay far below 2^62, so the sum never reaches the limits.
    assign e_next = sce_pkg::ENERGY_W'(pv_reg) + (sce_pkg::ENERGY_W'(ph_reg) <<< 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (en6) begin
                v6_reg <= in_valid;
            end
            if (en7) begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en6) begin
            pv_reg <= pv_next;
            ph_reg <= ph_next;
        end
        if (en7) begin
            e_reg <= e_next;
        end
    end

    assign out_valid = v7_reg;
    assign energy    = e_reg;

endmodule

// ----- hdl/schwinger_chain_diagonal_energy_unit.sv -----
// Path: an accepted input word is registered in prefix, terms and combine before its result reaches m_tdata.
// Throughput: one word per cycle; seven pipeline registers, each with its own
// valid bit, and a stall at the output fills bubbles before it holds s_tready.
// Reset: aresetn clears all valid bits, sets V and h to 0 and the site count
// to 32; no clearing pass is needed.
// ----------------------------------------------------------------------------
// schwinger_chain_diagonal_energy_unit
// Diagonal energy of the lattice Schwinger chain for a stream of basis states.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module schwinger_chain_diagonal_energy_unit #(
    parameter int MAX_SITES = sce_pkg::MAX_SITES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: basis_state[31:0]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sce_pkg::STATE_W-1:0]        s_tdata,
    // m_tdata: diag_energy[63:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sce_pkg::ENERGY_W-1:0]       m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sce_pkg::COEF_W-1:0]         cfg_data
);

    localparam int NW   = $clog2(MAX_SITES + 1);
    localparam int QW   = $clog2(MAX_SITES) + 1;
    localparam int AW   = $clog2(MAX_SITES + 1) + 1;
    localparam int KW   = 2 * $clog2(MAX_SITES) + 8;
    localparam int OCCW = $clog2(sce_pkg::PIPE_DEPTH + 1);

    logic signed [sce_pkg::COEF_W-1:0]   coupling_v_reg;
    logic signed [sce_pkg::COEF_W-1:0]   field_h_reg;
    logic [sce_pkg::SITE_W-1:0]          site_count_reg;
    logic [sce_pkg::SITE_W-1:0]          site_lim;
    logic [sce_pkg::SITE_W-1:0]          site_min;
    logic [NW-1:0]                       n_eff;

    logic                                p_valid;
    logic                                p_ready;
    logic signed [QW-1:0]                p_q [1:MAX_SITES-1];
    logic signed [AW-1:0]                p_a;
    logic                                t_valid;
    logic                                t_ready;
    logic signed [KW-1:0]                t_k;
    logic signed [AW-1:0]                t_a;
    logic signed [sce_pkg::ENERGY_W-1:0] energy;

    logic [OCCW-1:0]                     occ_reg;
    logic [OCCW-1:0]                     occ_next;
    logic                                in_acc;
    logic                                out_acc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coupling_v_reg <= '0;
            field_h_reg    <= '0;
            site_count_reg <= sce_pkg::SITE_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (sce_pkg::cfg_reg_t'(cfg_index))
                sce_pkg::REG_COUPLING_V: begin
                    coupling_v_reg <= cfg_data;
                end
                sce_pkg::REG_FIELD_H: begin
                    field_h_reg <= cfg_data;
                end
                sce_pkg::REG_SITE_COUNT: begin
                    site_count_reg <= cfg_data[sce_pkg::SITE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp to the supported range, then round down to an even site count.
    always_comb begin
        site_lim = (site_count_reg > sce_pkg::SITE_W'(MAX_SITES))
                 ? sce_pkg::SITE_W'(MAX_SITES) : site_count_reg;
        site_min = (site_lim < sce_pkg::SITE_W'(2)) ? sce_pkg::SITE_W'(2) : site_lim;
        n_eff    = NW'({site_min[sce_pkg::SITE_W-1:1], 1'b0});
    end

    sce_prefix #(
        .MAX_SITES (MAX_SITES)
    ) u_prefix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_state  (s_tdata),
        .n_eff     (n_eff),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .q_out     (p_q),
        .a_out     (p_a)
    );

    sce_terms #(
        .MAX_SITES (MAX_SITES)
    ) u_terms (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .q_in      (p_q),
        .a_in      (p_a),
        .n_eff     (n_eff),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .k_out     (t_k),
        .a_out     (t_a)
    );

    sce_combine #(
        .MAX_SITES (MAX_SITES)
    ) u_combine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (t_valid),
        .in_ready   (t_ready),
        .k_in       (t_k),
        .a_in       (t_a),
        .coupling_v (coupling_v_reg),
        .field_h    (field_h_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .energy     (energy)
    );

    assign m_tdata = energy;

    // Number of words inside the pipeline.
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        occ_next = occ_reg;
        if (in_acc && !out_acc) begin
            occ_next = occ_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    `SCE_ASSERT(a_occ_bound, aclk, aresetn, occ_reg <= OCCW'(sce_pkg::PIPE_DEPTH), "pipeline holds more words than stages")
    `SCE_ASSERT(a_out_has_word, aclk, aresetn, m_tvalid |-> occ_reg != '0, "result shown with no word in flight")
    `SCE_ASSERT(a_stall_full, aclk, aresetn, !s_tready |-> occ_reg == OCCW'(sce_pkg::PIPE_DEPTH), "input stalled while a stage is empty")
    `SCE_ASSERT(a_sites_even, aclk, aresetn, n_eff[0] == 1'b0 && n_eff >= NW'(2), "site count not even or below two")
    `SCE_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_tvalid && occ_reg == '0, "reset left a word in the pipeline")

endmodule
